### src/sle_pkg.sv
// shared types and codes for the sorted list engine
`default_nettype none

package sle_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_RETRIEVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic compare;
        logic ins;
        logic rem;
        logic found;
    } cell_ctrl_t;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

endpackage

`default_nettype wire

### src/sle_cell.sv
// one slot of the sorted list: compare against the request and shift with its neighbors
`default_nettype none

module sle_cell
    import sle_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic                  valid,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic                  prev_gt,
    input  wire logic [DATA_WIDTH-1:0] prev_entry,
    input  wire logic [DATA_WIDTH-1:0] next_entry,
    output logic      [DATA_WIDTH-1:0] entry,
    output logic                       gt,
    output logic                       hit
);

    logic [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                  gt_reg, eq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (ctrl.compare) begin
            gt_reg <= valid && ($signed(value) > $signed(entry_reg));
            eq_reg <= valid && (value == entry_reg);
        end
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            // insert point is the first cell whose entry is not smaller
            if (!gt_reg) begin
                entry_next = prev_gt ? value : prev_entry;
            end
        end else if (ctrl.rem && ctrl.found && !gt_reg) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    // equal entries sit together, so the first one follows the last smaller one
    assign hit   = eq_reg && prev_gt;

endmodule

`default_nettype wire

### src/sorted_list_engine.sv
// Sorted list engine: keeps up to CAPACITY signed entries in ascending order in a
// chain of cells. Each request takes three steps: accept, a compare step in which
// every cell checks its entry against the request in parallel, and an apply step in
// which cells shift one place toward or away from their neighbor and the result is
// registered. The result register lets the next request be accepted while a result
// waits; a new request is taken only once the previous one has left the chain.
`default_nettype none

module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // value[31:0], position[35:32]
    input  wire logic [1:0]            s_tuser,  // op[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,  // data_out[31:0], length[36:32]
    output logic      [1:0]            m_tuser   // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int LEN_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [3:0]            pos_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  m_tvalid_reg;
    status_t               status_reg;
    logic [31:0]           data_reg;
    logic [4:0]            len_reg;

    logic [63:0]           val_ext;
    logic                  go;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]   gt_w, hit_w, valid_w, sel_w;
    logic                  found;
    logic [DATA_WIDTH-1:0] rd_word;

    status_t               status_c;
    logic [31:0]           data_c;
    logic [CNT_W-1:0]      count_c;
    logic [LEN_W-1:0]      len_wide;
    logic [CMP_W-1:0]      pos_ext, cnt_ext;
    logic [63:0]           rd_ext;

    // only the low DATA_WIDTH bits are kept, so a wider entry sees the word zero-extended
    assign val_ext = 64'(s_tdata[31:0]);
    assign go      = !m_tvalid_reg || m_tready;

    always_comb begin
        ctrl.compare = (state_reg == S_CMP);
        ctrl.ins     = (state_reg == S_APPLY) && go && (op_reg == OP_INSERT)
                       && (count_reg != CNT_W'(CAPACITY));
        ctrl.rem     = (state_reg == S_APPLY) && go && (op_reg == OP_REMOVE);
        ctrl.found   = found;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  prev_gt;
        logic [DATA_WIDTH-1:0] prev_entry, next_entry;

        if (i == 0) begin : g_head
            assign prev_gt    = 1'b1;
            assign prev_entry = val_reg;
        end else begin : g_body
            assign prev_gt    = gt_w[i-1];
            assign prev_entry = entry_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign next_entry = entry_w[i];
        end else begin : g_mid
            assign next_entry = entry_w[i+1];
        end

        assign valid_w[i] = CNT_W'(i) < count_reg;
        assign sel_w[i]   = pos_ext == CMP_W'(i);

        sle_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .valid     (valid_w[i]),
            .value     (val_reg),
            .prev_gt   (prev_gt),
            .prev_entry(prev_entry),
            .next_entry(next_entry),
            .entry     (entry_w[i]),
            .gt        (gt_w[i]),
            .hit       (hit_w[i])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | (entry_w[i] & {DATA_WIDTH{sel_w[i]}});
        end
    end

    assign found   = |hit_w;
    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign rd_ext  = 64'(signed'(rd_word));

    always_comb begin
        status_c = ST_OK;
        data_c   = '0;
        count_c  = count_reg;
        unique case (op_reg)
            OP_INSERT: begin
                if (count_reg == CNT_W'(CAPACITY)) begin
                    status_c = ST_FULL;
                end else begin
                    count_c = count_reg + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    count_c = count_reg - 1'b1;
                end else begin
                    status_c = ST_NOT_FOUND;
                end
            end
            OP_RETRIEVE: begin
                if (pos_ext >= cnt_ext || pos_ext >= CMP_W'(CAPACITY)) begin
                    status_c = ST_RANGE;
                end else begin
                    data_c = rd_ext[31:0];
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    assign len_wide = LEN_W'(count_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in the apply cycle the new result takes over the output register
            if (m_tvalid_reg && m_tready && (state_reg != S_APPLY)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        val_reg   <= val_ext[DATA_WIDTH-1:0];
                        pos_reg   <= s_tdata[35:32];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (go) begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= status_c;
                        data_reg     <= data_c;
                        len_reg      <= len_wide[4:0];
                        count_reg    <= count_c;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, len_reg, data_reg};

endmodule

`default_nettype wire

### src/sle_checker.sv
// port-level checks for the sorted list engine, bound to the top level
`default_nettype none

module sle_checker
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]            m_tuser
);

    localparam logic [4:0] CAP_LEN = 5'(CAPACITY);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in the chain at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while chain busy");

    // a full report only comes with a full list
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[36:32] == CAP_LEN)
        else $error("full status with short list");

    // data is only returned on a successful request
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata[31:0] == 32'd0)
        else $error("data returned with error status");

    // with a capacity below 16, a range report never shows a length of 16
    a_range_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_RANGE) && (CAPACITY < 16) |-> m_tdata[36:32] != 5'd16)
        else $error("range status with inconsistent length");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);

`default_nettype wire

### tb/sorted_list_engine_test.sv
// self-checking testbench for the sorted list engine: directed table, then random requests
module sorted_list_engine_test;
    import sle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY         = 16;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 508;
    localparam int MAX_PRINTED      = 100;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic [4:0]  len;
    } list_result_t;

    typedef struct packed {
        logic [1:0]   op;
        logic [31:0]  value;
        logic [3:0]   pos;
        bit           fixed;
        list_result_t want;
    } stim_row_t;

    localparam list_result_t UNTYPED = '{ST_OK, 32'h0, 5'd0};
    localparam int DIRECTED_ROWS = 26;

    // rows with fixed set carry their own expectation, the rest go through the list model
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_RETRIEVE, 32'h00000000, 4'd0,  1'b1, '{ST_RANGE,     32'h0, 5'd0}},
        '{OP_REMOVE,   32'h00000005, 4'd0,  1'b1, '{ST_NOT_FOUND, 32'h0, 5'd0}},
        '{OP_UNUSED,   32'hffffffff, 4'd15, 1'b1, '{ST_OK,        32'h0, 5'd0}},
        '{OP_INSERT,   32'h7fffffff, 4'd0,  1'b1, '{ST_OK,        32'h0, 5'd1}},
        '{OP_INSERT,   32'h80000000, 4'd15, 1'b1, '{ST_OK,        32'h0, 5'd2}},
        '{OP_RETRIEVE, 32'h00000000, 4'd0,  1'b1, '{ST_OK, 32'h80000000, 5'd2}},
        '{OP_INSERT,   32'h00000000, 4'd5,  1'b1, '{ST_OK,        32'h0, 5'd3}},
        '{OP_INSERT,   32'hffffffff, 4'd10, 1'b0, UNTYPED},
        '{OP_INSERT,   32'h00000000, 4'd3,  1'b0, UNTYPED},
        '{OP_REMOVE,   32'h00000000, 4'd12, 1'b0, UNTYPED},
        '{OP_RETRIEVE, 32'h00000000, 4'd15, 1'b1, '{ST_RANGE,     32'h0, 5'd4}},
        '{OP_INSERT,   32'h00000001, 4'd1,  1'b0, UNTYPED},
        '{OP_INSERT,   32'hfffffffe, 4'd2,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h55555555, 4'd4,  1'b0, UNTYPED},
        '{OP_INSERT,   32'haaaaaaaa, 4'd8,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h12345678, 4'd6,  1'b0, UNTYPED},
        '{OP_INSERT,   32'hedcba987, 4'd9,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h7ffffffe, 4'd7,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h80000001, 4'd11, 1'b0, UNTYPED},
        '{OP_INSERT,   32'h00010000, 4'd13, 1'b0, UNTYPED},
        '{OP_INSERT,   32'hffff0000, 4'd14, 1'b0, UNTYPED},
        '{OP_INSERT,   32'h0000ffff, 4'd0,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h00000002, 4'd5,  1'b0, UNTYPED},
        '{OP_INSERT,   32'h80000000, 4'd0,  1'b1, '{ST_FULL,      32'h0, 5'd16}},
        '{OP_RETRIEVE, 32'h00000000, 4'd15, 1'b1, '{ST_OK, 32'h7fffffff, 5'd16}},
        '{OP_REMOVE,   32'h80000000, 4'd0,  1'b1, '{ST_OK,        32'h0, 5'd15}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // value[31:0], position[35:32]
    logic [1:0]  s_tuser  = '0;  // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // data_out[31:0], length[36:32]
    logic [1:0]  m_tuser;        // status[1:0]

    logic         req_taken = 1'b0;
    bit           row_fixed = 1'b0;
    list_result_t row_exp   = UNTYPED;

    // list model state, updated when a request is taken
    logic signed [31:0] list_model [CAPACITY];
    int                 list_count = 0;

    list_result_t result_q [$];
    list_result_t predicted, want;
    int mismatches   = 0;
    int requests     = 0;
    int results      = 0;
    int stall_cycles = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int full_seen    = 0;
    int empty_seen   = 0;
    int send_idle    = 14;
    int recv_idle    = 74;
    bit growing      = 1'b1;
    int burst_left   = 30;

    sorted_list_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic list_result_t list_apply(input logic [1:0] op,
                                                input logic signed [31:0] val,
                                                input logic [3:0] pos);
        list_result_t r;
        int slot;
        r = UNTYPED;
        slot = 0;
        if (op == OP_INSERT) begin
            if (list_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // equal values go in front of existing equal entries
                while (slot < list_count && val > list_model[slot]) slot++;
                for (int i = list_count; i > slot; i--) list_model[i] = list_model[i - 1];
                list_model[slot] = val;
                list_count++;
            end
        end else if (op == OP_REMOVE) begin
            while (slot < list_count && list_model[slot] != val) slot++;
            if (slot >= list_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (int i = slot; i + 1 < list_count; i++) list_model[i] = list_model[i + 1];
                list_count--;
            end
        end else if (op == OP_RETRIEVE) begin
            if (pos >= list_count) begin
                r.status = ST_RANGE;
            end else begin
                r.data = list_model[pos];
            end
        end
        r.len = list_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (mismatches < MAX_PRINTED)
            $display("mismatch in %s at result %0d: got %h, expected %h",
                     what, results, got, exp_val);
        mismatches++;
    endtask

    // request and result monitor, plus list model update
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                results++;
                if (result_q.size() == 0) begin
                    report_mismatch("result with no request pending", m_tdata[31:0], 32'h0);
                end else begin
                    want = result_q.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] != want.data)
                        report_mismatch("data_out", m_tdata[31:0], want.data);
                    if (m_tdata[36:32] != want.len)
                        report_mismatch("length", 32'(m_tdata[36:32]), 32'(want.len));
                end
                status_seen[m_tuser]++;
                if (m_tdata[36:32] == 5'd16) full_seen++;
                if (m_tdata[36:32] == 5'd0) empty_seen++;
            end
            if (s_tvalid && s_tready) begin
                requests++;
                predicted = list_apply(s_tuser, s_tdata[31:0], s_tdata[35:32]);
                result_q.push_back(row_fixed ? row_exp : predicted);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic issue(input logic [1:0] op, input logic [31:0] val, input logic [3:0] pos,
                         input bit fixed, input list_result_t exp_res);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {4'b0, pos, val};
        row_fixed <= fixed;
        row_exp   <= exp_res;
        @(negedge aclk);
        while (!req_taken) @(negedge aclk);
    endtask

    task automatic random_request();
        logic [1:0]  op;
        logic [31:0] val;
        logic [3:0]  pos;
        int pick, hit, ins_share, rem_share;
        // alternate bursts that fill and drain the list so both ends are reached
        burst_left--;
        if (burst_left <= 0) begin
            growing    = !growing;
            burst_left = $urandom_range(20, 60);
        end
        ins_share = growing ? 60 : 20;
        rem_share = growing ? 20 : 60;
        pick = $urandom_range(99);
        if (pick < 3) op = OP_UNUSED;
        else if (pick < 3 + ins_share) op = OP_INSERT;
        else if (pick < 3 + ins_share + rem_share) op = OP_REMOVE;
        else op = OP_RETRIEVE;
        hit  = (op == OP_REMOVE) ? 7 : 4;
        pick = $urandom_range(9);
        if (list_count != 0 && pick < hit) begin
            val = list_model[$urandom_range(list_count - 1)];
        end else if (pick < hit + 2) begin
            case ($urandom_range(4))
                0:       val = 32'h80000000;
                1:       val = 32'h7fffffff;
                2:       val = 32'h00000000;
                3:       val = 32'hffffffff;
                default: val = $urandom_range(3);
            endcase
        end else begin
            val = $urandom;
        end
        pos = $urandom_range(15);
        issue(op, val, pos, 1'b0, UNTYPED);
    endtask

    initial begin : stimulus
        int ph;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                  directed_rows[i].fixed, directed_rows[i].want);
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 14;
                    recv_idle = 74;
                end
                1: begin
                    send_idle = 74;
                    recv_idle = 14;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) random_request();
        end
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests: %0d ok, %0d full, %0d not found, %0d beyond count",
                 requests, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_NOT_FOUND], status_seen[ST_RANGE]);
        $display("%0d results, list full %0d times and empty %0d times, %0d mismatches",
                 results, full_seen, empty_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
src/sle_pkg.sv
src/sle_cell.sv
src/sorted_list_engine.sv
src/sle_checker.sv
tb/sorted_list_engine_test.sv
